// ===== hw/rtl/base64_custom_alphabet_decoder_defines.svh =====
// Assertion macros used by the decoder RTL.
`ifndef BASE64_CUSTOM_ALPHABET_DECODER_DEFINES_SVH
`define BASE64_CUSTOM_ALPHABET_DECODER_DEFINES_SVH

// Check a property on every rising clock edge, skipped while reset is held.
`define B64D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// Types, constants and the alphabet lookup of the base64 decoder.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam int unsigned MAX_RES = 4;

    // One decoded symbol: ok is low for a byte outside the alphabet.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sym;

    // One result transaction, without its last-of-step flag.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       msg_end;
        logic       bad_char;
    } t_res;

    // All results of one input item, first result in res[0].
    typedef struct packed {
        logic [2:0]     cnt;
        t_res [MAX_RES-1:0] res;
    } t_bundle;

    localparam t_res RES_NONE = '{data: 8'h00, has_byte: 1'b0, msg_end: 1'b0, bad_char: 1'b0};

    // Alphabet: ZYX A..W zyx a..w 0..9 + /
    function automatic t_sym sym_lookup(input logic [7:0] c);
        t_sym       s;
        logic [7:0] t;
        s = '{ok: 1'b1, val: 6'd0};
        t = 8'h00;
        if (c == 8'h5A) begin
            s.val = 6'd0;
        end else if (c == 8'h59) begin
            s.val = 6'd1;
        end else if (c == 8'h58) begin
            s.val = 6'd2;
        end else if (c >= 8'h41 && c <= 8'h57) begin
            t     = c - 8'h41 + 8'd3;
            s.val = t[5:0];
        end else if (c == 8'h7A) begin
            s.val = 6'd26;
        end else if (c == 8'h79) begin
            s.val = 6'd27;
        end else if (c == 8'h78) begin
            s.val = 6'd28;
        end else if (c >= 8'h61 && c <= 8'h77) begin
            t     = c - 8'h61 + 8'd29;
            s.val = t[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t     = c - 8'h30 + 8'd52;
            s.val = t[5:0];
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.ok  = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_group.sv =====
// Group state and single-pass decode of one character into its result bundle.
`default_nettype none

module b64d_group (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_last,
    output b64d_pkg::t_bundle      o_bundle
);
    import b64d_pkg::*;

    logic [1:0]  r_gp,   n_gp;
    logic [23:0] r_acc,  n_acc;
    logic [2:0]  r_pad,  n_pad;
    logic        r_skip, n_skip;

    t_sym        sym;
    logic        bad;
    logic [23:0] acc_upd;
    logic [2:0]  pad_upd;
    logic [3:0]  pad_tot;
    logic [1:0]  nbytes;
    logic [2:0]  npre;
    t_res [MAX_RES-1:0] pre;
    t_res        term;
    logic        flush;

    always_comb begin
        sym     = sym_lookup(i_char);
        acc_upd = r_acc;
        pad_upd = r_pad;
        bad     = 1'b0;
        if (!r_skip) begin
            if (i_char == PAD_CHAR) begin
                pad_upd = r_pad + 3'd1;
            end else if (!sym.ok) begin
                bad = 1'b1;
            end else begin
                unique case (r_gp)
                    2'd0:    acc_upd = r_acc | {sym.val, 18'd0};
                    2'd1:    acc_upd = r_acc | {6'd0, sym.val, 12'd0};
                    2'd2:    acc_upd = r_acc | {12'd0, sym.val, 6'd0};
                    default: acc_upd = r_acc | {18'd0, sym.val};
                endcase
            end
        end
    end

    // Close the group on its fourth value or at message end; missing slots pad.
    assign flush   = !r_skip && !bad && ((r_gp == 2'd3) || i_last);
    assign pad_tot = {1'b0, pad_upd} + {2'd0, 2'd3 - r_gp};
    assign nbytes  = (pad_tot >= 4'd3) ? 2'd0 : 2'(4'd3 - pad_tot);

    always_comb begin
        pre = {MAX_RES{RES_NONE}};
        if (bad) begin
            pre[0]          = RES_NONE;
            pre[0].bad_char = 1'b1;
            npre            = 3'd1;
        end else if (flush) begin
            pre[0] = '{data: acc_upd[23:16], has_byte: 1'b1, msg_end: 1'b0, bad_char: 1'b0};
            pre[1] = '{data: acc_upd[15:8],  has_byte: 1'b1, msg_end: 1'b0, bad_char: 1'b0};
            pre[2] = '{data: acc_upd[7:0],   has_byte: 1'b1, msg_end: 1'b0, bad_char: 1'b0};
            npre   = {1'b0, nbytes};
        end else begin
            npre   = 3'd0;
        end
    end

    always_comb begin
        n_skip = r_skip || bad;
        if (bad || flush) begin
            n_gp  = 2'd0;
            n_acc = 24'd0;
            n_pad = 3'd0;
        end else if (r_skip) begin
            n_gp  = r_gp;
            n_acc = r_acc;
            n_pad = r_pad;
        end else begin
            n_gp  = r_gp + 2'd1;
            n_acc = acc_upd;
            n_pad = pad_upd;
        end
        term          = RES_NONE;
        term.msg_end  = 1'b1;
        term.bad_char = n_skip;
        if (i_last) begin
            n_gp   = 2'd0;
            n_acc  = 24'd0;
            n_pad  = 3'd0;
            n_skip = 1'b0;
        end
    end

    // Place the byte or error results first, then the terminator.
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < npre) begin
                o_bundle.res[k] = pre[k];
            end else if (3'(k) == npre && i_last) begin
                o_bundle.res[k] = term;
            end else begin
                o_bundle.res[k] = RES_NONE;
            end
        end
        o_bundle.cnt = npre + {2'd0, i_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp   <= 2'd0;
            r_acc  <= 24'd0;
            r_pad  <= 3'd0;
            r_skip <= 1'b0;
        end else if (i_take) begin
            r_gp   <= n_gp;
            r_acc  <= n_acc;
            r_pad  <= n_pad;
            r_skip <= n_skip;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_emit.sv =====
// Result register that holds one bundle and plays it out one transaction a cycle while the receiver is ready.
`default_nettype none
`include "base64_custom_alphabet_decoder_defines.svh"

module b64d_emit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  b64d_pkg::t_bundle      i_bundle,
    output logic                   o_free,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic [2:0]             o_m_tuser,
    output logic                   o_m_tlast
);
    import b64d_pkg::*;

    logic               r_valid;
    logic [1:0]         r_idx;
    logic [2:0]         r_cnt;
    t_res [MAX_RES-1:0] r_res;
    t_res               cur;
    logic               at_last;
    logic               fire;

    assign cur     = r_res[r_idx];
    assign at_last = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign fire    = r_valid && i_m_tready;
    assign o_free  = !r_valid || (fire && at_last);

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = cur.data;
    assign o_m_tlast  = cur.msg_end;
    assign o_m_tuser  = {at_last, cur.bad_char, cur.has_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (fire) begin
            r_valid <= !at_last;
            r_idx   <= r_idx + 2'd1;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_res <= i_bundle.res;
        end
    end

    `B64D_ASSERT(a_load_when_free, i_load |-> o_free, "bundle loaded over a busy result register")
    `B64D_ASSERT(a_idx_in_range, r_valid |-> ({1'b0, r_idx} < r_cnt), "result index past bundle count")
    `B64D_ASSERT(a_load_starts, i_load |=> (r_valid && r_idx == 2'd0), "load did not start a bundle")
    `B64D_ASSERT(a_end_is_last, (o_m_tvalid && o_m_tlast) |-> o_m_tuser[2], "terminator not last of step")
    `B64D_ASSERT_ALWAYS(a_reset_idle, !$past(i_rst_n) |-> !r_valid, "result valid right after reset")

endmodule

`default_nettype wire

// ===== hw/rtl/base64_custom_alphabet_decoder.sv =====
// Top level of the permuted-alphabet base64 decoder.
//
//  channel   dir  tdata          tuser                                  tlast
//  s (char)  in   in_char[7:0]   -                                      is_last
//  m (res)   out  out_byte[7:0]  has_byte, bad_char, last_of_step       message_end
//
// An accepted character sits in the input register, where the lookup
// and group update run in one pass; its results load into the result register.
// The result register plays out one transaction per cycle while i_m_tready is
// high, so an item with n results (0 to 4) holds it while they play out.
// Characters that give no result flow at one per cycle while the result register is free.
// Reset (i_rst_n low, synchronous) empties both registers and clears the group.
// A stall on the master side holds the result register; the input register
// then fills and o_s_tready drops.
`default_nettype none

module base64_custom_alphabet_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_char
    input  wire logic       i_s_tlast,   // is_last
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [2:0]      o_m_tuser,   // [0] has_byte, [1] bad_char, [2] last_of_step
    output logic            o_m_tlast    // message_end
);
    import b64d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    t_bundle    bundle;
    logic       res_free;
    logic       take;
    logic       load;

    // Advance the held character once the result register can take its bundle.
    assign take       = r_in_valid && res_free;
    // Characters with no result only update the group state.
    assign load       = take && (bundle.cnt != 3'd0);
    assign o_s_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the character payload while it waits.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    b64d_group u_group (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_bundle (bundle)
    );

    b64d_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bundle   (bundle),
        .o_free     (res_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/base64_custom_alphabet_decoder_tb.sv =====
// Self-checking bench for the permuted-alphabet base64 decoder: directed table, then random messages.
`timescale 1ns / 1ps

module base64_custom_alphabet_decoder_tb;
    import b64d_pkg::PAD_CHAR;

    localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
    localparam int LONG_HOLD    = 250;     // receiver hold-off that fills the pipe
    localparam int DRAIN_CYCLES = 20;      // wait well past the block latency
    localparam int RANDOM_ITEMS = 256;
    localparam int CALM_TAIL    = 40;      // items at the end sent with no idling
    localparam int PRINT_CAP    = 40;

    // Symbol value 0 first.
    string symbols = "ZYXABCDEFGHIJKLMNOPQRSTUVWzyxabcdefghijklmnopqrstuvw0123456789+/";

    // One decoded result transaction, as it appears on the master side.
    typedef struct packed {
        logic       msg_end;
        logic       step_last;
        logic       bad_char;
        logic       has_byte;
        logic [7:0] data;
    } t_dec_res;

    // One stimulus row; typed rows carry their own expected results.
    typedef struct packed {
        logic              typed;
        logic [2:0]        n_res;
        t_dec_res [3:0]    res;
        logic              last;
        logic [7:0]        ch;
    } t_char_row;

    localparam t_dec_res NO_RES = '0;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] in_char
    logic       i_s_tlast;   // is_last
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic [2:0] o_m_tuser;   // [0] has_byte, [1] bad_char, [2] last_of_step
    logic       o_m_tlast;   // message_end

    base64_custom_alphabet_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_char_row stim_q[$];
    t_dec_res  pending_results[$];
    int        accepted_chars = 0;
    int        mismatch_cnt   = 0;
    int        cycle_cnt      = 0;
    bit        send_done      = 0;
    bit        long_hold_done = 0;

    // Decoder shadow state.
    logic [1:0]  grp_pos;
    logic [23:0] bit_acc;
    logic [2:0]  pad_cnt;
    logic        skip_rest;

    // 20 ns clock.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int symbol_index(input logic [7:0] c);
        int i;
        for (i = 0; i < 64; i++) begin
            if (symbols[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic logic [7:0] pick_symbol();
        return symbols[$urandom_range(0, 63)];
    endfunction

    function automatic t_dec_res byte_res(input logic [7:0] d, input logic fin);
        t_dec_res r;
        r = NO_RES;
        r.data      = d;
        r.has_byte  = 1'b1;
        r.step_last = fin;
        return r;
    endfunction

    function automatic t_dec_res err_res(input logic fin);
        t_dec_res r;
        r = NO_RES;
        r.bad_char  = 1'b1;
        r.step_last = fin;
        return r;
    endfunction

    // The terminator always closes its step.
    function automatic t_dec_res term_res(input logic bad);
        t_dec_res r;
        r = NO_RES;
        r.msg_end   = 1'b1;
        r.bad_char  = bad;
        r.step_last = 1'b1;
        return r;
    endfunction

    function automatic t_char_row row(input logic [7:0] c, input logic last);
        t_char_row r;
        r = '0;
        r.ch   = c;
        r.last = last;
        return r;
    endfunction

    function automatic t_char_row trow(input logic [7:0] c, input logic last, input int n,
                                       input t_dec_res r0 = NO_RES, input t_dec_res r1 = NO_RES,
                                       input t_dec_res r2 = NO_RES, input t_dec_res r3 = NO_RES);
        t_char_row r;
        r = row(c, last);
        r.typed  = 1'b1;
        r.n_res  = n[2:0];
        r.res[0] = r0;
        r.res[1] = r1;
        r.res[2] = r2;
        r.res[3] = r3;
        return r;
    endfunction

    // True once the run is in its final, idle-free stretch.
    function automatic bit in_final_stretch();
        return accepted_chars + CALM_TAIL >= stim_q.size();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Predict the results of one accepted character and advance the shadow state.
    task automatic decode_char(input logic [7:0] c, input logic last, ref t_dec_res outs[$]);
        int          v;
        int          cnt;
        int          pad;
        int          nbytes;
        int          k;
        int          shift;
        logic        bad;
        logic [23:0] sym24;
        bad = 1'b0;
        if (!skip_rest) begin
            shift = 18 - 6 * grp_pos;
            if (c == PAD_CHAR) begin
                pad_cnt = pad_cnt + 3'd1;
            end else begin
                v = symbol_index(c);
                if (v < 0) begin
                    bad = 1'b1;
                end else begin
                    sym24   = 24'(v);
                    bit_acc = bit_acc | (sym24 << shift);
                end
            end
            if (bad) begin
                outs.push_back(err_res(1'b0));
                skip_rest = 1'b1;
                grp_pos   = '0;
                bit_acc   = '0;
                pad_cnt   = '0;
            end else begin
                cnt = grp_pos + 1;
                if (cnt == 4 || last) begin
                    // Missing positions of an early end count as padding.
                    pad    = pad_cnt + (4 - cnt);
                    nbytes = (pad >= 3) ? 0 : 3 - pad;
                    for (k = 0; k < nbytes; k++)
                        outs.push_back(byte_res(bit_acc[(16 - 8 * k) +: 8], 1'b0));
                    grp_pos = '0;
                    bit_acc = '0;
                    pad_cnt = '0;
                end else begin
                    grp_pos = cnt[1:0];
                end
            end
        end
        if (last) begin
            outs.push_back(term_res(skip_rest));
            grp_pos   = '0;
            bit_acc   = '0;
            pad_cnt   = '0;
            skip_rest = 1'b0;
        end
        if (outs.size() > 0) outs[outs.size() - 1].step_last = 1'b1;
    endtask

    // Monitor: sample both handshakes at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_char_row r;
        t_dec_res  outs[$];
        t_dec_res  want;
        int        k;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                r = stim_q[accepted_chars];
                outs.delete();
                // Keep the shadow state in step even on typed rows.
                decode_char(i_s_tdata, i_s_tlast, outs);
                if (r.typed) begin
                    for (k = 0; k < r.n_res; k++) pending_results.push_back(r.res[k]);
                end else begin
                    for (k = 0; k < outs.size(); k++) pending_results.push_back(outs[k]);
                end
                accepted_chars++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", o_m_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata !== want.data)
                        report_mismatch("out_byte", o_m_tdata, want.data);
                    if (o_m_tuser[0] !== want.has_byte)
                        report_mismatch("has_byte", o_m_tuser[0], want.has_byte);
                    if (o_m_tuser[1] !== want.bad_char)
                        report_mismatch("bad_char", o_m_tuser[1], want.bad_char);
                    if (o_m_tuser[2] !== want.step_last)
                        report_mismatch("last_of_step", o_m_tuser[2], want.step_last);
                    if (o_m_tlast !== want.msg_end)
                        report_mismatch("message_end", o_m_tlast, want.msg_end);
                end
            end
        end
    end

    // Sender: offer characters at the falling edge, with random gaps.
    initial begin : sender
        int i;
        int calm;
        calm       = 0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tlast  = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        for (i = 0; i < stim_q.size(); i++) begin
            if (calm == 0 && !in_final_stretch() && $urandom_range(0, 3) == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            // Open an idle-free stretch now and then.
            if (calm > 0) calm--;
            else if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 60);
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= stim_q[i].ch;
            i_s_tlast  <= stim_q[i].last;
            // Hold the transaction until the block takes it.
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b0;
        send_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial begin : receiver
        int calm;
        calm       = 0;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (!long_hold_done && accepted_chars >= 80) begin
                long_hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (calm == 0 && !in_final_stretch() && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            if (calm > 0) calm--;
            else if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 60);
            i_m_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Watchdog: end the run as failed once it reaches the cycle limit.
    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : main
        logic [7:0] msg[$];
        logic [7:0] c;
        int         n_rand;
        int         kind;
        int         g;
        int         p;
        int         len;
        int         bad_pos;
        int         j;

        grp_pos   = '0;
        bit_acc   = '0;
        pad_cnt   = '0;
        skip_rest = 1'b0;

        // Directed table.
        // Lowest symbol in every position: three zero bytes.
        stim_q.push_back(trow("Z", 1'b0, 0));
        stim_q.push_back(trow("Z", 1'b0, 0));
        stim_q.push_back(trow("Z", 1'b0, 0));
        stim_q.push_back(trow("Z", 1'b0, 3, byte_res(8'h00, 1'b0), byte_res(8'h00, 1'b0),
                              byte_res(8'h00, 1'b1)));
        // Highest symbol, group closed by the message end: all four results on one item.
        stim_q.push_back(trow("/", 1'b0, 0));
        stim_q.push_back(trow("/", 1'b0, 0));
        stim_q.push_back(trow("/", 1'b0, 0));
        stim_q.push_back(trow("/", 1'b1, 4, byte_res(8'hFF, 1'b0), byte_res(8'hFF, 1'b0),
                              byte_res(8'hFF, 1'b0), term_res(1'b0)));
        // One pad at the end of a group.
        stim_q.push_back(row("Q", 1'b0));
        stim_q.push_back(row("U", 1'b0));
        stim_q.push_back(row("J", 1'b0));
        stim_q.push_back(row(PAD_CHAR, 1'b0));
        // Message ending after one symbol: three missing positions, terminator only.
        stim_q.push_back(trow("x", 1'b1, 1, term_res(1'b0)));
        // Padding in every position, including the first.
        stim_q.push_back(row(PAD_CHAR, 1'b0));
        stim_q.push_back(row(PAD_CHAR, 1'b0));
        stim_q.push_back(row(PAD_CHAR, 1'b0));
        stim_q.push_back(row(PAD_CHAR, 1'b0));
        // Byte zero is invalid; then skip until the end, which reports the error.
        stim_q.push_back(trow(8'h00, 1'b0, 1, err_res(1'b1)));
        stim_q.push_back(trow("A", 1'b0, 0));
        stim_q.push_back(trow(8'hFF, 1'b1, 1, term_res(1'b1)));
        // Invalid character that is also the last one.
        stim_q.push_back(trow("!", 1'b1, 2, err_res(1'b0), term_res(1'b1)));
        // Early end after two symbols: one byte.
        stim_q.push_back(row("9", 1'b0));
        stim_q.push_back(row("w", 1'b1));

        // Random messages, mostly well formed.
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            msg.delete();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4, 5: begin
                    // Full groups, then an optional padded or short final group.
                    g = $urandom_range(0, 3);
                    p = $urandom_range(0, 2);
                    if (g == 0 && p == 0) g = 1;
                    repeat (4 * g) msg.push_back(pick_symbol());
                    if (p == 1) begin
                        len = $urandom_range(1, 2);
                        repeat (4 - len) msg.push_back(pick_symbol());
                        repeat (len) msg.push_back(PAD_CHAR);
                    end else if (p == 2) begin
                        repeat ($urandom_range(2, 3)) msg.push_back(pick_symbol());
                    end
                    n_rand += msg.size();
                end
                6: begin
                    // Odd lengths with stray padding.
                    len = $urandom_range(1, 9);
                    for (j = 0; j < len; j++)
                        msg.push_back(($urandom_range(0, 4) == 0) ? PAD_CHAR : pick_symbol());
                    n_rand += msg.size();
                end
                7: begin
                    // One character outside the alphabet somewhere in the message.
                    len     = $urandom_range(2, 10);
                    bad_pos = $urandom_range(0, len - 1);
                    for (j = 0; j < len; j++) begin
                        if (j == bad_pos) begin
                            c = 8'($urandom_range(0, 255));
                            while (c == PAD_CHAR || symbol_index(c) >= 0)
                                c = 8'($urandom_range(0, 255));
                            msg.push_back(c);
                        end else begin
                            msg.push_back(pick_symbol());
                        end
                    end
                    n_rand += msg.size();
                end
                default: begin
                    // Raw noise over the whole byte range.
                    len = $urandom_range(1, 6);
                    repeat (len) msg.push_back(8'($urandom_range(0, 255)));
                    n_rand += len;
                end
            endcase
            for (j = 0; j < msg.size(); j++)
                stim_q.push_back(row(msg[j], j == msg.size() - 1));
        end

        // Synchronous reset, released at a falling edge.
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last result, then watch a little longer for strays.
        while (!(send_done && pending_results.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
